// ----- design/char_lcd_text_number_writer_macros.svh -----
// Assertion macros shared by the character LCD writer modules.
`ifndef CHAR_LCD_TEXT_NUMBER_WRITER_MACROS_SVH
`define CHAR_LCD_TEXT_NUMBER_WRITER_MACROS_SVH
`ifndef SYNTHESIS
// Checked on every clock edge outside reset
`define CLD_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);
// Checked on every clock edge, reset included
`define CLD_ASSERT_RST(name, prop, msg) \
  name: assert property (@(posedge clk) prop) \
    else $error(msg);
`else
`define CLD_ASSERT(name, prop, msg)
`define CLD_ASSERT_RST(name, prop, msg)
`endif
`endif

// ----- design/cld_pkg.sv -----
// Types, constants and helpers of the character LCD writer.
package cld_pkg;

  // Display geometry
  localparam int COLUMNS = 16;
  localparam int ROWS    = 2;

  // Field widths
  localparam int VALUE_W = 16;
  localparam int COL_W   = 4;
  localparam int BYTE_W  = 8;
  localparam int NIB_W   = 4;

  // Decimal conversion
  localparam int BIN_W  = VALUE_W;
  localparam int DIGITS = 5;
  localparam int BCD_W  = DIGITS * NIB_W;
  localparam int CNT_W  = $clog2(BIN_W + 1);
  localparam int REM_W  = $clog2(DIGITS + 1);

  // Function codes
  localparam logic FUNC_NUM  = 1'b0;
  localparam logic FUNC_TEXT = 1'b1;

  // Display command bytes and address wrap points
  localparam logic [BYTE_W-1:0] ADDR_CMD   = 8'h80;
  localparam logic [BYTE_W-1:0] ROW_OFS    = 8'h40;
  localparam logic [BYTE_W-1:0] WRAP1_FROM = 8'h90;
  localparam logic [BYTE_W-1:0] WRAP1_TO   = 8'hC0;
  localparam logic [BYTE_W-1:0] WRAP2_FROM = 8'hD0;
  localparam logic [BYTE_W-1:0] WRAP2_TO   = 8'h80;
  localparam logic [BYTE_W-1:0] ASCII_ZERO = 8'd48;

  // Pending result bits of a text request
  localparam int P_WRAP = 0;
  localparam int P_CHAR = 1;
  localparam int P_ADDR = 2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_TEXT,
    S_NADDR,
    S_NDIG
  } cld_state_t;

  typedef struct packed {
    logic start;
    logic pop;
  } cld_bcd_ctl_t;

  typedef struct packed {
    logic             done;
    logic [NIB_W-1:0] digit;
  } cld_bcd_sts_t;

  function automatic logic pos_ok(input logic [COL_W-1:0] col, input logic row);
    return (int'(col) < COLUMNS) && (int'(row) < ROWS);
  endfunction

  function automatic logic [BYTE_W-1:0] start_addr(input logic [COL_W-1:0] col,
                                                   input logic row);
    return ADDR_CMD | (BYTE_W'(col) + (row ? ROW_OFS : 8'h00));
  endfunction

endpackage

// ----- design/cld_if.sv -----
// Request and result channel interfaces of the character LCD writer.
interface cld_in_if import cld_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               func;
  logic [VALUE_W-1:0] value;
  logic [COL_W-1:0]   col;
  logic               row;
  logic               first;

  modport source (output valid, func, value, col, row, first, input ready);
  modport sink   (input valid, func, value, col, row, first, output ready);
endinterface

interface cld_out_if import cld_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              bus_write;
  logic              is_data;
  logic [BYTE_W-1:0] bus_byte;
  logic              last;
  logic              error;

  modport source (output valid, bus_write, is_data, bus_byte, last, error, input ready);
  modport sink   (input valid, bus_write, is_data, bus_byte, last, error, output ready);
endinterface

// ----- design/cld_bcd.sv -----
// Bit-serial binary to BCD converter with a digit shift-out port.
`include "char_lcd_text_number_writer_macros.svh"
module cld_bcd import cld_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  cld_bcd_ctl_t       ctl,
  input  logic [VALUE_W-1:0] value,
  output cld_bcd_sts_t       sts
);

  logic [BIN_W-1:0] bin_r, bin_nxt;
  logic [BCD_W-1:0] bcd_r, bcd_nxt;
  logic [BCD_W-1:0] adj;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // add-3 correction on every nibble before the shift
  always_comb begin
    adj = bcd_r;
    for (int i = 0; i < DIGITS; i++) begin
      if (bcd_r[i*NIB_W +: NIB_W] >= 4'd5) begin
        adj[i*NIB_W +: NIB_W] = bcd_r[i*NIB_W +: NIB_W] + 4'd3;
      end
    end
  end

  // one binary bit per cycle, then one digit per pop
  always_comb begin
    bin_nxt = bin_r;
    bcd_nxt = bcd_r;
    cnt_nxt = cnt_r;
    if (ctl.start) begin
      bin_nxt = value;
      bcd_nxt = '0;
      cnt_nxt = CNT_W'(BIN_W);
    end else if (cnt_r != '0) begin
      bcd_nxt = {adj[BCD_W-2:0], bin_r[BIN_W-1]};
      bin_nxt = {bin_r[BIN_W-2:0], 1'b0};
      cnt_nxt = cnt_r - CNT_W'(1);
    end else if (ctl.pop) begin
      bcd_nxt = {bcd_r[BCD_W-NIB_W-1:0], {NIB_W{1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
  end

  assign sts.done  = (cnt_r == '0);
  assign sts.digit = bcd_r[BCD_W-1 -: NIB_W];

  `CLD_ASSERT(a_pop_done, ctl.pop |-> cnt_r == '0, "digit popped during conversion")
  `CLD_ASSERT(a_start_cnt, ctl.start |=> cnt_r == CNT_W'(BIN_W), "conversion did not start")
  `CLD_ASSERT_RST(a_rst_cnt, !rst_n |=> cnt_r == '0, "bit counter not cleared by reset")

endmodule

// ----- design/char_lcd_text_number_writer.sv -----
// Top level: turns text characters and numbers into character LCD bus writes.
//
// Usage:
//   in_ch  carries one request: func selects a decimal number (value, 16 bits)
//          or one text character (value[7:0]); col/row give the start place,
//          first marks a character that opens a new string.
//   out_ch carries the results in order: address commands (is_data low),
//          data bytes (is_data high) or an error report (bus_write low).
//          last marks the final result of a request.
//   A request is taken only when the previous one has placed all its
//   results in the output register; one request is in work at a time.
//   A text request gives up to three results, one per cycle unless out_ch stalls.
//   A number gives its address command from state S_NADDR after it is taken; a
//   16-bit bit-serial conversion runs meanwhile, then five digit places
//   follow at one per cycle unless out_ch stalls (leading zeros dropped).
//   Requests that cause no result leave the sequencer idle.
//   Reset (rst_n low, synchronous) empties the output register, sets the
//   cursor address to row 0 column 0 and ends any string in progress.
//   When the receiver stalls, the held result stays and the sequencer
//   waits; no result is dropped or repeated.
`include "char_lcd_text_number_writer_macros.svh"
module char_lcd_text_number_writer import cld_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  cld_in_if.sink   in_ch,
  cld_out_if.source out_ch
);

  cld_state_t state_r, state_nxt;

  logic [BYTE_W-1:0] text_addr_r, text_addr_nxt;
  logic              str_act_r, str_act_nxt;

  logic [2:0]        pend_r, pend_nxt;
  logic              cmd_err_r, cmd_err_nxt;
  logic [BYTE_W-1:0] cmd_byte_r, cmd_byte_nxt;
  logic [BYTE_W-1:0] ch_r, ch_nxt;
  logic [BYTE_W-1:0] wrap_byte_r, wrap_byte_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic              lead_r, lead_nxt;

  logic              ov_r, ov_nxt;
  logic              o_wr_r, o_wr_nxt;
  logic              o_dat_r, o_dat_nxt;
  logic [BYTE_W-1:0] o_byte_r, o_byte_nxt;
  logic              o_last_r, o_last_nxt;
  logic              o_err_r, o_err_nxt;

  logic              accept, can_load, ok;
  logic              emit, e_wr, e_dat, e_last, e_err;
  logic [BYTE_W-1:0] e_byte;
  logic [BYTE_W-1:0] ch_in, base_addr, inc_addr, new_addr, start;
  logic              act, wrap1, wrap2, t_char, t_wrap;

  cld_bcd_ctl_t bcd_ctl;
  cld_bcd_sts_t bcd_sts;

  cld_bcd u_bcd (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (bcd_ctl),
    .value (in_ch.value),
    .sts   (bcd_sts)
  );

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign can_load    = !ov_r || out_ch.ready;

  // text cursor update for a character request
  always_comb begin
    ok        = pos_ok(in_ch.col, in_ch.row);
    start     = start_addr(in_ch.col, in_ch.row);
    ch_in     = in_ch.value[BYTE_W-1:0];
    base_addr = in_ch.first ? start : text_addr_r;
    act       = in_ch.first ? ok : str_act_r;
    inc_addr  = base_addr + BYTE_W'(1);
    wrap1     = (inc_addr == WRAP1_FROM);
    wrap2     = (inc_addr == WRAP2_FROM);
    new_addr  = wrap1 ? WRAP1_TO : (wrap2 ? WRAP2_TO : inc_addr);
    t_char    = act && (ch_in != '0);
    t_wrap    = t_char && (wrap1 || wrap2);
  end

  // sequencer: next state, cursor state and the result to load
  always_comb begin
    state_nxt     = state_r;
    text_addr_nxt = text_addr_r;
    str_act_nxt   = str_act_r;
    pend_nxt      = pend_r;
    cmd_err_nxt   = cmd_err_r;
    cmd_byte_nxt  = cmd_byte_r;
    ch_nxt        = ch_r;
    wrap_byte_nxt = wrap_byte_r;
    rem_nxt       = rem_r;
    lead_nxt      = lead_r;
    bcd_ctl       = '0;
    emit          = 1'b0;
    e_wr          = 1'b1;
    e_dat         = 1'b0;
    e_byte        = cmd_byte_r;
    e_last        = 1'b0;
    e_err         = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_ch.func == FUNC_NUM) begin
            if (ok) begin
              str_act_nxt   = 1'b0;
              cmd_byte_nxt  = start;
              bcd_ctl.start = 1'b1;
              state_nxt     = S_NADDR;
            end
          end else begin
            pend_nxt      = {in_ch.first, t_char, t_wrap};
            cmd_err_nxt   = !ok;
            cmd_byte_nxt  = ok ? start : '0;
            ch_nxt        = ch_in;
            wrap_byte_nxt = new_addr;
            str_act_nxt   = t_char;
            if (t_char) begin
              text_addr_nxt = new_addr;
            end else if (in_ch.first && ok) begin
              text_addr_nxt = start;
            end
            if (in_ch.first || t_char) begin
              state_nxt = S_TEXT;
            end
          end
        end
      end

      S_TEXT: begin
        if (can_load) begin
          emit   = 1'b1;
          e_last = ((pend_r & (pend_r - 3'd1)) == 3'd0);
          if (pend_r[P_ADDR]) begin
            e_wr             = !cmd_err_r;
            e_err            = cmd_err_r;
            e_byte           = cmd_byte_r;
            pend_nxt[P_ADDR] = 1'b0;
          end else if (pend_r[P_CHAR]) begin
            e_dat            = 1'b1;
            e_byte           = ch_r;
            pend_nxt[P_CHAR] = 1'b0;
          end else begin
            e_byte           = wrap_byte_r;
            pend_nxt[P_WRAP] = 1'b0;
          end
          if (e_last) begin
            state_nxt = S_IDLE;
          end
        end
      end

      S_NADDR: begin
        if (can_load) begin
          emit      = 1'b1;
          e_byte    = cmd_byte_r;
          rem_nxt   = REM_W'(DIGITS);
          lead_nxt  = 1'b1;
          state_nxt = S_NDIG;
        end
      end

      S_NDIG: begin
        if (bcd_sts.done) begin
          if (lead_r && (bcd_sts.digit == '0) && (rem_r > REM_W'(1))) begin
            // leading zero digit: drop it
            bcd_ctl.pop = 1'b1;
            rem_nxt     = rem_r - REM_W'(1);
          end else if (can_load) begin
            emit        = 1'b1;
            e_dat       = 1'b1;
            e_byte      = ASCII_ZERO + BYTE_W'(bcd_sts.digit);
            e_last      = (rem_r == REM_W'(1));
            bcd_ctl.pop = 1'b1;
            rem_nxt     = rem_r - REM_W'(1);
            lead_nxt    = 1'b0;
            if (e_last) begin
              state_nxt = S_IDLE;
            end
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // output register
  always_comb begin
    ov_nxt     = ov_r && !out_ch.ready;
    o_wr_nxt   = o_wr_r;
    o_dat_nxt  = o_dat_r;
    o_byte_nxt = o_byte_r;
    o_last_nxt = o_last_r;
    o_err_nxt  = o_err_r;
    if (emit) begin
      ov_nxt     = 1'b1;
      o_wr_nxt   = e_wr;
      o_dat_nxt  = e_dat;
      o_byte_nxt = e_byte;
      o_last_nxt = e_last;
      o_err_nxt  = e_err;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      text_addr_r <= ADDR_CMD;
      str_act_r   <= 1'b0;
      pend_r      <= '0;
      ov_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      text_addr_r <= text_addr_nxt;
      str_act_r   <= str_act_nxt;
      pend_r      <= pend_nxt;
      ov_r        <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_err_r   <= cmd_err_nxt;
    cmd_byte_r  <= cmd_byte_nxt;
    ch_r        <= ch_nxt;
    wrap_byte_r <= wrap_byte_nxt;
    rem_r       <= rem_nxt;
    lead_r      <= lead_nxt;
    o_wr_r      <= o_wr_nxt;
    o_dat_r     <= o_dat_nxt;
    o_byte_r    <= o_byte_nxt;
    o_last_r    <= o_last_nxt;
    o_err_r     <= o_err_nxt;
  end

  assign out_ch.valid     = ov_r;
  assign out_ch.bus_write = o_wr_r;
  assign out_ch.is_data   = o_dat_r;
  assign out_ch.bus_byte  = o_byte_r;
  assign out_ch.last      = o_last_r;
  assign out_ch.error     = o_err_r;

  `CLD_ASSERT(a_err_last, ov_r && o_err_r |-> o_last_r && !o_wr_r, "error report not final")
  `CLD_ASSERT(a_text_pend, state_r == S_TEXT |-> pend_r != '0, "text state with nothing pending")
  `CLD_ASSERT(a_num_ends_str, accept && in_ch.func == FUNC_NUM && ok |=> !str_act_r, "number left string open")

endmodule
